/* design/rvs_pkg.sv */
// ---------------------------------------------------------------------------
// rvs_pkg
// Shared types and constants of the relative vorticity stencil.
// ---------------------------------------------------------------------------
package rvs_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 512;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COLS_W    = COL_W + 1;
    localparam int ROWS_W    = ROW_W + 1;
    localparam int WIND_W    = 24;
    localparam int COS_W     = 16;
    localparam int UCOS_W    = 26;
    localparam int COEF_W    = 32;
    localparam int VORT_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DV_W      = WIND_W + 1;
    localparam int DU_W      = UCOS_W + 1;
    localparam int RAD_W     = 23;
    localparam int DEN_W     = RAD_W + COS_W;
    localparam int QUO_W     = 31;

    localparam logic [RAD_W-1:0] EARTH_RADIUS = RAD_W'(6371000);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HALF_INV_DPHI    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_INV_DLAMBDA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE      = 3'd3;

    // One unit of work handed from the front to the back
    typedef struct packed {
        logic                     zero;     // row one: result is zero
        logic                     two;      // last row: also emit its zero row
        logic [ROW_W-1:0]         row;      // row of the incoming item
        logic [COL_W-1:0]         col;
        logic signed [DV_W-1:0]   dv;
        logic signed [DU_W-1:0]   du;
        logic [COS_W-1:0]         cs;
    } job_t;

endpackage

/* design/rvs_if.sv */
// ---------------------------------------------------------------------------
// rvs_in_if, rvs_out_if, rvs_cfg_if
// Valid/ready channels of the relative vorticity stencil.
// ---------------------------------------------------------------------------
interface rvs_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [23:0]        u_wind;
    logic signed [23:0]        v_wind;
    logic [15:0]               cos_lat;
    modport source (output valid, u_wind, v_wind, cos_lat, input ready);
    modport sink (input valid, u_wind, v_wind, cos_lat, output ready);
endinterface

interface rvs_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [31:0]        vorticity;
    logic [8:0]                lat_index;
    logic [9:0]                lon_index;
    logic                      saturated;
    logic                      last;
    modport source (output valid, vorticity, lat_index, lon_index, saturated, last,
                    input ready);
    modport sink (input valid, vorticity, lat_index, lon_index, saturated, last,
                  output ready);
endinterface

interface rvs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                index;
    logic [31:0]               data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/rvs_ram.sv */
// ---------------------------------------------------------------------------
// rvs_ram
// Generic one-write one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/rvs_queue.sv */
// ---------------------------------------------------------------------------
// rvs_queue
// Four-entry job queue between the front and the back.
// ---------------------------------------------------------------------------
module rvs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rvs_pkg::job_t push_data,
    output logic          push_ready,
    input  logic          pop,
    output rvs_pkg::job_t pop_data,
    output logic          pop_valid
);
    import rvs_pkg::*;

    job_t       slot_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    assign push_ready = (count_reg != 3'd4);
    assign pop_valid  = (count_reg != 3'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && push_ready)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push && push_ready) - 3'(pop && pop_valid);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 3'd4)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'd4 && !(pop && pop_valid)) |=> count_reg == 3'd4)
        else $error("queue lost a job");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'd0 && push) |=> pop_valid)
        else $error("pushed job not visible");
endmodule

/* design/rvs_front.sv */
// ---------------------------------------------------------------------------
// rvs_front
// Accepts grid points, keeps the row line buffers and forms difference jobs.
// ---------------------------------------------------------------------------
module rvs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    rvs_in_if.sink                       in_ch,
    input  logic [rvs_pkg::ROWS_W-1:0]   rows_in_use,
    input  logic [rvs_pkg::COLS_W-1:0]   cols_in_use,
    output logic                         job_push,
    output rvs_pkg::job_t                job_data,
    input  logic                         job_ready
);
    import rvs_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RD2  = 3'b010,
        F_WR   = 3'b100
    } fstate_t;

    fstate_t                  state_reg, state_next;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_reg;
    logic signed [WIND_W-1:0] v_first_reg, v_left_reg, v_cur_reg, v_in_reg;
    logic signed [WIND_W-1:0] v_prev_reg;
    logic signed [WIND_W-1:0] u_in_reg;
    logic [COS_W-1:0]         cs_in_reg, cos_old_reg;
    logic signed [UCOS_W-1:0] ucos_reg;

    logic [COLS_W-1:0]        cols_c;
    logic [ROWS_W-1:0]        rows_c;
    logic                     last_col, last_row, finish;
    logic [COL_W-1:0]         nbr_addr, v_raddr;
    logic signed [WIND_W-1:0] v_rdata;
    logic [UCOS_W-1:0]        old_rdata, older_rdata;
    logic signed [WIND_W-1:0] right, left;
    logic signed [WIND_W+COS_W:0] prod;

    // Clamp geometry
    always_comb
    begin
        cols_c = (cols_in_use < COLS_W'(3)) ? COLS_W'(3) :
                 (cols_in_use > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : cols_in_use;
        rows_c = (rows_in_use < ROWS_W'(3)) ? ROWS_W'(3) :
                 (rows_in_use > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows_in_use;
    end

    assign last_col = {1'b0, col_reg} >= cols_c - COLS_W'(1);
    assign last_row = {1'b0, row_reg} >= rows_c - ROWS_W'(1);
    // Right neighbor; the left one of column zero is the last point written
    assign nbr_addr = col_reg + COL_W'(1);
    assign v_raddr  = (state_reg == F_IDLE) ? col_reg : nbr_addr;
    assign in_ch.ready = (state_reg == F_IDLE);
    assign finish = (state_reg == F_WR) && (job_ready || row_reg == '0);
    assign prod = u_in_reg * $signed({1'b0, cs_in_reg});

    rvs_ram #(.WIDTH(WIND_W), .DEPTH(MAX_COLS)) u_v_ram (
        .clk(clk), .we(finish), .waddr(col_reg), .wdata(v_in_reg),
        .raddr(v_raddr), .rdata(v_rdata)
    );
    rvs_ram #(.WIDTH(UCOS_W), .DEPTH(MAX_COLS)) u_old_ram (
        .clk(clk), .we(finish), .waddr(col_reg), .wdata(ucos_reg),
        .raddr(col_reg), .rdata(old_rdata)
    );
    rvs_ram #(.WIDTH(UCOS_W), .DEPTH(MAX_COLS)) u_older_ram (
        .clk(clk), .we(finish), .waddr(col_reg), .wdata(old_rdata),
        .raddr(col_reg), .rdata(older_rdata)
    );

    // Form the job from buffered neighbors
    always_comb
    begin
        right = last_col ? v_first_reg : v_rdata;
        left  = (col_reg == '0) ? v_prev_reg : v_left_reg;
        job_data.zero = (row_reg == ROW_W'(1));
        job_data.two  = last_row;
        job_data.row  = row_reg;
        job_data.col  = col_reg;
        job_data.dv   = DV_W'(right) - DV_W'(left);
        job_data.du   = DU_W'(ucos_reg) - DU_W'($signed(older_rdata));
        job_data.cs   = cos_old_reg;
        job_push      = (state_reg == F_WR) && (row_reg != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (in_ch.valid) state_next = F_RD2;
            F_RD2:  state_next = F_WR;
            F_WR:   if (finish) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Latch input and intermediate values
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            u_in_reg  <= in_ch.u_wind;
            v_in_reg  <= in_ch.v_wind;
            cs_in_reg <= in_ch.cos_lat;
        end
        if (state_reg == F_RD2)
        begin
            v_cur_reg <= v_rdata;
            ucos_reg  <= prod[WIND_W+COS_W:15];
        end
    end

    // Advance counters and row registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            v_first_reg <= '0;
            v_left_reg  <= '0;
            v_prev_reg  <= '0;
            cos_old_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                if (col_reg == '0)
                begin
                    v_first_reg <= v_cur_reg;
                end
                v_left_reg <= v_cur_reg;
                v_prev_reg <= v_in_reg;
                if (last_col)
                begin
                    col_reg     <= '0;
                    cos_old_reg <= cs_in_reg;
                    row_reg     <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_WR && !finish) |=> state_reg == F_WR && $stable(col_reg))
        else $error("front moved while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_RD2) |=> state_reg == F_WR)
        else $error("front skipped write state");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> row_reg != '0)
        else $error("row zero produced a job");
endmodule

/* design/rvs_back.sv */
// ---------------------------------------------------------------------------
// rvs_back
// Scales differences, divides by R cos bit-serially and emits results.
// ---------------------------------------------------------------------------
module rvs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rvs_pkg::COEF_W-1:0]   half_inv_dphi,
    input  logic [rvs_pkg::COEF_W-1:0]   half_inv_dlambda,
    input  rvs_pkg::job_t                job_data,
    input  logic                         job_valid,
    output logic                         job_pop,
    rvs_out_if.source                    out_ch
);
    import rvs_pkg::*;

    localparam int P1_W  = DV_W + COEF_W + 1;
    localparam int P2_W  = DU_W + COEF_W + 1;
    localparam int NUM_W = P2_W + 1;
    localparam int REM_W = DEN_W + 1;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL  = 6'b000010,
        B_SUB  = 6'b000100,
        B_CHK  = 6'b001000,
        B_DIV  = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    localparam logic signed [VORT_W-1:0] VMAX = {1'b0, {(VORT_W-1){1'b1}}};
    localparam logic signed [VORT_W-1:0] VMIN = {1'b1, {(VORT_W-1){1'b0}}};

    bstate_t                  state_reg;
    job_t                     job_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic [DEN_W-1:0]         den_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [4:0]               cnt_reg;
    logic                     neg_reg;
    logic signed [VORT_W-1:0] vort_reg;
    logic [ROW_W-1:0]         lat_reg;
    logic [COL_W-1:0]         lon_reg;
    logic                     sat_reg, last_reg;

    logic [NUM_W-1:0]         mag;
    logic [REM_W:0]           rem2;
    logic                     fits;
    logic [QUO_W-1:0]         quo_new;

    assign out_ch.valid     = (state_reg == B_OUT);
    assign out_ch.vorticity = vort_reg;
    assign out_ch.lat_index = lat_reg;
    assign out_ch.lon_index = lon_reg;
    assign out_ch.saturated = sat_reg;
    assign out_ch.last      = last_reg;
    assign job_pop          = (state_reg == B_IDLE) && job_valid;

    // Magnitude and one division step
    always_comb
    begin
        mag     = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        rem2    = {rem_reg, 1'b0};
        fits    = rem2 >= {2'b00, den_reg};
        quo_new = {quo_reg[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg  <= job_data;
                vort_reg <= '0;
                sat_reg  <= 1'b0;
                last_reg <= !job_data.two;
                lat_reg  <= job_data.row - ROW_W'(1);
                lon_reg  <= job_data.col;
            end
            B_MUL:
            begin
                p1_reg  <= job_reg.dv * $signed({1'b0, half_inv_dlambda});
                p2_reg  <= job_reg.du * $signed({1'b0, half_inv_dphi});
                den_reg <= EARTH_RADIUS * job_reg.cs;
            end
            B_SUB:
            begin
                num_reg <= NUM_W'(p1_reg) - NUM_W'(p2_reg);
            end
            B_CHK:
            begin
                neg_reg <= num_reg[NUM_W-1];
                rem_reg <= REM_W'(mag);
                quo_reg <= '0;
                cnt_reg <= '0;
                if (den_reg == '0)
                begin
                    sat_reg  <= 1'b1;
                    vort_reg <= num_reg[NUM_W-1] ? VMIN : ((num_reg != '0) ? VMAX : '0);
                end
                else if (num_reg[NUM_W-1] && mag == NUM_W'(den_reg))
                begin
                    vort_reg <= VMIN;
                end
                else if (mag >= NUM_W'(den_reg))
                begin
                    sat_reg  <= 1'b1;
                    vort_reg <= num_reg[NUM_W-1] ? VMIN : VMAX;
                end
            end
            B_DIV:
            begin
                rem_reg <= fits ? REM_W'(rem2 - {2'b00, den_reg}) : REM_W'(rem2);
                quo_reg <= quo_new;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1))
                begin
                    vort_reg <= neg_reg ? -VORT_W'(quo_new) : VORT_W'(quo_new);
                end
            end
            B_OUT:
            begin
                if (out_ch.ready && !last_reg)
                begin
                    vort_reg <= '0;
                    sat_reg  <= 1'b0;
                    last_reg <= 1'b1;
                    lat_reg  <= job_reg.row;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequence the work of one job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            case (state_reg)
                B_IDLE: if (job_valid) state_reg <= job_data.zero ? B_OUT : B_MUL;
                B_MUL:  state_reg <= B_SUB;
                B_SUB:  state_reg <= B_CHK;
                B_CHK:
                    if (den_reg != '0 && mag < NUM_W'(den_reg))
                        state_reg <= B_DIV;
                    else
                        state_reg <= B_OUT;
                B_DIV:  if (cnt_reg == 5'(QUO_W - 1)) state_reg <= B_OUT;
                B_OUT:  if (out_ch.ready && last_reg) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> cnt_reg < 5'(QUO_W))
        else $error("division ran too long");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && sat_reg) |-> (vort_reg == VMAX || vort_reg == VMIN
                                       || vort_reg == '0))
        else $error("saturated result not at a limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("pop from empty queue");
endmodule

/* design/relative_vorticity_stencil.sv */
// ---------------------------------------------------------------------------
// relative_vorticity_stencil
// Streaming relative vorticity on a latitude-longitude grid.
//
//   channel  dir  payload                                         done when
//   in_ch    in   u_wind, v_wind, cos_lat                         valid&ready
//   out_ch   out  vorticity, lat_index, lon_index, saturated, last valid&ready
//   cfg      in   index, data                                     valid&ready
//
// The front takes one grid point at a time (two line-buffer RAM reads,
// then the write-back, which waits for queue room). The back takes each
// interior result through pop, multiply, subtract, check and bit-serial
// divide (skipped on saturation), then output; row-one results go from pop
// to output. A 4-job queue lets the front run ahead. Reset clears control
// state; line buffers need no clearing. Either side may stall at any time.
// ---------------------------------------------------------------------------
module relative_vorticity_stencil (
    input  logic      clk,
    input  logic      rst_n,
    rvs_in_if.sink    in_ch,
    rvs_out_if.source out_ch,
    rvs_cfg_if.sink   cfg
);
    import rvs_pkg::*;

    logic [COEF_W-1:0] half_inv_dphi_reg, half_inv_dlambda_reg;
    logic [ROWS_W-1:0] rows_in_use_reg;
    logic [COLS_W-1:0] cols_in_use_reg;
    logic              push, push_ready, pop, pop_valid;
    job_t              push_data, pop_data;

    assign cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_inv_dphi_reg    <= COEF_W'(65536);
            half_inv_dlambda_reg <= COEF_W'(65536);
            rows_in_use_reg      <= ROWS_W'(181);
            cols_in_use_reg      <= COLS_W'(360);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HALF_INV_DPHI:    half_inv_dphi_reg    <= cfg.data;
                REG_HALF_INV_DLAMBDA: half_inv_dlambda_reg <= cfg.data;
                REG_ROWS_IN_USE:      rows_in_use_reg      <= cfg.data[ROWS_W-1:0];
                REG_COLS_IN_USE:      cols_in_use_reg      <= cfg.data[COLS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rvs_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .rows_in_use(rows_in_use_reg), .cols_in_use(cols_in_use_reg),
        .job_push(push), .job_data(push_data), .job_ready(push_ready)
    );

    rvs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .push_ready(push_ready), .pop(pop), .pop_data(pop_data), .pop_valid(pop_valid)
    );

    rvs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .half_inv_dphi(half_inv_dphi_reg), .half_inv_dlambda(half_inv_dlambda_reg),
        .job_data(pop_data), .job_valid(pop_valid), .job_pop(pop), .out_ch(out_ch)
    );
endmodule

/* test/relative_vorticity_stencil_test.sv */
// ---------------------------------------------------------------------------
// relative_vorticity_stencil_test
// Streams whole latitude-longitude slices through the stencil under several
// grid geometries and scale factors, predicts each vorticity result with an
// in-bench model of the line buffers and the divide, and checks every output
// transaction field by field. Both channels idle at random, and one long
// output stall backs the block up into its input.
// ---------------------------------------------------------------------------
module relative_vorticity_stencil_test;
    import rvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [23:0] u;
        logic signed [23:0] v;
        logic [15:0]        cs;
    } grid_point_t;

    typedef struct {
        logic signed [31:0] vort;
        logic [8:0]         lat;
        logic [9:0]         lon;
        logic               sat;
        logic               last;
    } vort_result_t;

    logic clk;
    logic rst_n;

    rvs_in_if  in_ch ();
    rvs_out_if out_ch ();
    rvs_cfg_if cfg ();

    relative_vorticity_stencil DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    grid_point_t  pending_points[$];
    vort_result_t expected_vort[$];

    int error_count;
    int points_taken;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    bit stall_done;
    longint cycle_count;

    // predictor copy of the registers and line buffers
    logic [31:0] dphi_scale;
    logic [31:0] dlambda_scale;
    logic [9:0]  rows_reg;
    logic [10:0] cols_reg;
    longint      ucos_line_older[MAX_COLS];
    longint      ucos_line_old[MAX_COLS];
    longint      v_line_old[MAX_COLS];
    longint      v_first_prev;
    longint      v_left_prev;
    int unsigned cos_prev_row;
    int unsigned row_pos;
    int unsigned col_pos;

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Divide a Q.24 numerator by R * cos, truncating the magnitude
    function automatic logic signed [31:0] divide_by_radius(input longint num,
                                                            input int unsigned cs,
                                                            output logic sat);
        longint unsigned d;
        longint unsigned mag;
        longint unsigned rem;
        longint unsigned q;
        bit neg;
        neg = num < 0;
        q = 0;
        if (cs == 0)
        begin
            sat = 1'b1;
            return (num > 0) ? 32'sh7FFF_FFFF : ((num < 0) ? 32'sh8000_0000 : 32'sd0);
        end
        d = 64'd6371000 * longint'(cs);
        mag = neg ? longint'(-num) : longint'(num);
        if (neg && mag == d)
        begin
            sat = 1'b0;
            return 32'sh8000_0000;
        end
        if (mag >= d)
        begin
            sat = 1'b1;
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        rem = mag;
        for (int i = 0; i < 31; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q = q | 64'd1;
            end
        end
        sat = 1'b0;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic int unsigned clamp_geom(input int unsigned x, input int unsigned hi);
        return (x < 3) ? 3 : ((x > hi) ? hi : x);
    endfunction

    // Append a grid point to the pending queue
    task automatic add_point(input grid_point_t p);
        pending_points.insert(pending_points.size(), p);
    endtask

    // Advance the stencil by one grid point and queue the results it causes
    task automatic predict_point(input grid_point_t p);
        int unsigned cols;
        int unsigned rows;
        int unsigned row;
        int unsigned c;
        bit last_col;
        bit last_row;
        longint ucos;
        longint right;
        longint left;
        longint num;
        vort_result_t r;
        cols = clamp_geom(cols_reg, MAX_COLS);
        rows = clamp_geom(rows_reg, MAX_ROWS);
        row = row_pos;
        c = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
        last_col = c >= cols - 1;
        last_row = row >= rows - 1;
        ucos = (longint'(p.u) * longint'(p.cs)) >>> 15;

        if (row >= 1)
        begin
            r.lat = 9'(row - 1);
            r.lon = 10'(c);
            r.last = !last_row;
            if (row == 1)
            begin
                r.vort = '0;
                r.sat = 1'b0;
            end
            else
            begin
                right = last_col ? v_first_prev : v_line_old[c + 1];
                left = (c == 0) ? v_line_old[cols - 1] : v_left_prev;
                num = (right - left) * longint'(dlambda_scale)
                      - (ucos - ucos_line_older[c]) * longint'(dphi_scale);
                r.vort = divide_by_radius(num, cos_prev_row, r.sat);
            end
            expected_vort.insert(expected_vort.size(), r);
            if (last_row)
            begin
                r.vort = '0;
                r.lat = 9'(row);
                r.sat = 1'b0;
                r.last = 1'b1;
                expected_vort.insert(expected_vort.size(), r);
            end
        end

        if (c == 0)
            v_first_prev = v_line_old[0];
        v_left_prev = v_line_old[c];
        v_line_old[c] = longint'(p.v);
        ucos_line_older[c] = ucos_line_old[c];
        ucos_line_old[c] = ucos;

        if (last_col)
        begin
            col_pos = 0;
            cos_prev_row = p.cs;
            row_pos = last_row ? 0 : row + 1;
        end
        else
            col_pos = c + 1;
    endtask

    // Drive the input channel from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid   <= 1'b1;
                in_ch.u_wind  <= pending_points[0].u;
                in_ch.v_wind  <= pending_points[0].v;
                in_ch.cos_lat <= pending_points[0].cs;
                void'(pending_points.pop_front());
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Predict on every input transaction
    always @(posedge clk)
    begin
        grid_point_t p;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            p.u = in_ch.u_wind;
            p.v = in_ch.v_wind;
            p.cs = in_ch.cos_lat;
            predict_point(p);
            points_taken <= points_taken + 1;
        end
    end

    // Track register writes
    always @(posedge clk)
    begin
        if (rst_n && cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_HALF_INV_DPHI:    dphi_scale = cfg.data;
                REG_HALF_INV_DLAMBDA: dlambda_scale = cfg.data;
                REG_ROWS_IN_USE:      rows_reg = cfg.data[9:0];
                REG_COLS_IN_USE:      cols_reg = cfg.data[10:0];
                default:              ;
            endcase
        end
    end

    // Output ready: random idling plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!stall_done && points_taken >= 300)
        begin
            stall_done <= 1'b1;
            stall_left <= 800;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each output transaction against the oldest expectation
    always @(posedge clk)
    begin
        vort_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_vort.size() == 0)
            begin
                $error("unexpected result lat %0d lon %0d", out_ch.lat_index, out_ch.lon_index);
                error_count++;
            end
            else
            begin
                e = expected_vort.pop_front();
                if (out_ch.vorticity !== e.vort)
                begin
                    $error("vorticity: expected %0d, got %0d", e.vort, out_ch.vorticity);
                    error_count++;
                end
                if (out_ch.lat_index !== e.lat)
                begin
                    $error("lat_index: expected %0d, got %0d", e.lat, out_ch.lat_index);
                    error_count++;
                end
                if (out_ch.lon_index !== e.lon)
                begin
                    $error("lon_index: expected %0d, got %0d", e.lon, out_ch.lon_index);
                    error_count++;
                end
                if (out_ch.saturated !== e.sat)
                begin
                    $error("saturated: expected %0d, got %0d", e.sat, out_ch.saturated);
                    error_count++;
                end
                if (out_ch.last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, out_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd4_000_000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hold until the block has delivered everything, then let it settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_points.size() > 0 || in_ch.valid || expected_vort.size() > 0);
        repeat (200) @(posedge clk);
    endtask

    // Offer one register write and drop valid right after it is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [31:0] dphi, input logic [31:0] dlam,
                            input logic [31:0] rows_w, input logic [31:0] cols_w);
        write_reg(REG_HALF_INV_DPHI, dphi);
        write_reg(REG_HALF_INV_DLAMBDA, dlam);
        write_reg(REG_ROWS_IN_USE, rows_w);
        write_reg(REG_COLS_IN_USE, cols_w);
    endtask

    function automatic logic signed [23:0] rand_wind(input bit full);
        if (full)
            return 24'($urandom());
        return 24'(int'($urandom_range(4000)) - 2000);
    endfunction

    // Queue whole slices with random winds and one cosine per row
    task automatic queue_slices(input int unsigned rows, input int unsigned cols,
                                input int slices);
        grid_point_t p;
        bit full;
        for (int s = 0; s < slices; s++)
        begin
            full = 1'($urandom_range(1));
            for (int r = 0; r < rows; r++)
            begin
                case ($urandom_range(9))
                    0:       p.cs = 16'd0;
                    1:       p.cs = 16'd32768;
                    default: p.cs = 16'($urandom_range(32767));
                endcase
                for (int c = 0; c < cols; c++)
                begin
                    p.u = rand_wind(full);
                    p.v = rand_wind(full);
                    add_point(p);
                end
            end
        end
    endtask

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom() >> $urandom_range(8, 20);
        endcase
    endfunction

    function automatic grid_point_t make_point(input logic signed [23:0] u,
                                               input logic signed [23:0] v,
                                               input logic [15:0] cs);
        grid_point_t p;
        p.u = u;
        p.v = v;
        p.cs = cs;
        return p;
    endfunction

    initial
    begin
        int unsigned rows;
        int unsigned cols;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.u_wind = '0;
        in_ch.v_wind = '0;
        in_ch.cos_lat = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        out_ch.ready = 1'b0;
        error_count = 0;
        points_taken = 0;
        stall_left = 0;
        stall_done = 1'b0;
        cycle_count = 0;
        send_idle_pct = 24;
        recv_idle_pct = 61;
        dphi_scale = 32'd65536;
        dlambda_scale = 32'd65536;
        rows_reg = 10'd181;
        cols_reg = 11'd360;
        v_first_prev = 0;
        v_left_prev = 0;
        cos_prev_row = 0;
        row_pos = 0;
        col_pos = 0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            ucos_line_older[i] = 0;
            ucos_line_old[i] = 0;
            v_line_old[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: 3x3 slices, rows register below range, extreme scales
        set_grid(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd3);
        // extreme winds, middle row with zero cosine
        for (int c = 0; c < 3; c++)
            add_point(make_point(24'sh7FFFFF, (c == 1) ? 24'sh800000 : 24'sh7FFFFF,
                                 16'd32768));
        for (int c = 0; c < 3; c++)
            add_point(make_point(24'sh800000, 24'sh7FFFFF, 16'd0));
        for (int c = 0; c < 3; c++)
            add_point(make_point(24'sh800000, 24'sh800000, 16'd32768));
        // zero numerator over a zero cosine
        for (int i = 0; i < 9; i++)
            add_point(make_point(24'sd0, 24'sd0, 16'd0));
        // extreme winds over full cosine: clipping both ways
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                add_point(make_point((r == 2) ? 24'sh800000 : 24'sh7FFFFF,
                                     (c == 0) ? 24'sh800000 : 24'sh7FFFFF,
                                     16'd32768));
        wait_drained();

        // Random phases on small grids
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 24;
            end
            else if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            rows = $urandom_range(3, 8);
            cols = $urandom_range(3, 12);
            set_grid(rand_scale(), rand_scale(),
                     {22'($urandom_range(32'h3F_FFFF)), 10'(rows)},
                     {21'($urandom_range(32'h1F_FFFF)), 11'(cols)});
            queue_slices(rows, cols, $urandom_range(2, 4));
            wait_drained();
        end

        if (error_count == 0 && expected_vort.size() == 0)
            $display("Test completed successfully");
        else
        begin
            if (expected_vort.size() > 0)
                $error("%0d results never arrived", expected_vort.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* relative_vorticity_stencil.f */
design/rvs_pkg.sv
design/rvs_if.sv
design/rvs_ram.sv
design/rvs_queue.sv
design/rvs_front.sv
design/rvs_back.sv
design/relative_vorticity_stencil.sv
test/relative_vorticity_stencil_test.sv
